[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the compass heading block.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CHXY_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define CHXY_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

[hw/rtl/chxy_pkg.sv]
// Package for the compass heading block: CORDIC angle table and fixed widths.
// Depends on nothing; used by chxy_cordic_stage and the top level.
`default_nettype none

package chxy_pkg;

   // Fraction bits of the CORDIC angle accumulator (units of 2^-24 degree).
   localparam int TABLE_FRAC = 24;
   localparam int TABLE_LEN  = 24;

   // Signed angle accumulator: about +/-512 degrees at 24 fraction bits.
   localparam int ANGLE_WIDTH = 34;

   // Width of the configuration registers and of the whole-degree result.
   localparam int REG_WIDTH   = 9;
   // Signed whole-degree heading before the wrap (roughly +/-450).
   localparam int WHOLE_WIDTH = 11;

   // atan(2^-i) in degrees, rounded to units of 2^-24 degree.
   localparam logic [31:0] ATAN_TABLE [TABLE_LEN] = '{
      32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
      32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
      32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
      32'd234684,    32'd117342,    32'd58671,     32'd29335,
      32'd14668,     32'd7334,      32'd3667,      32'd1833,
      32'd917,       32'd458,       32'd229,       32'd115
   };

   // Ninety degrees in accumulator units.
   localparam logic signed [ANGLE_WIDTH-1:0] QUARTER_TURN =
      ANGLE_WIDTH'(64'sd90 <<< TABLE_FRAC);

   // Modulus constants for the wrap stages.
   localparam logic signed [WHOLE_WIDTH-1:0] FULL_TURN_S = WHOLE_WIDTH'(360);
   localparam logic [REG_WIDTH:0] FULL_TURN_U = (REG_WIDTH + 1)'(360);
   localparam logic [REG_WIDTH:0] TWO_TURNS_U = (REG_WIDTH + 1)'(720);

   // Register indexes on the configuration port.
   typedef enum logic {
      CSR_DECLINATION  = 1'b0,
      CSR_MOUNT_OFFSET = 1'b1
   } csr_index_type;

endpackage

`default_nettype wire

[hw/rtl/chxy_cordic_stage.sv]
// One registered micro-rotation of the vectoring CORDIC.
// Depends on chxy_pkg for the angle table and accumulator width.
`default_nettype none

module chxy_cordic_stage #(
   parameter int DATA_WIDTH = 43,
   parameter int STAGE      = 0
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     advance,
   input  logic                                     prev_valid,
   input  logic                                     prev_zero,
   input  logic signed [DATA_WIDTH-1:0]             prev_h,
   input  logic signed [DATA_WIDTH-1:0]             prev_v,
   input  logic signed [chxy_pkg::ANGLE_WIDTH-1:0]  prev_z,
   output logic                                     valid_ff,
   output logic                                     zero_ff,
   output logic signed [DATA_WIDTH-1:0]             h_ff,
   output logic signed [DATA_WIDTH-1:0]             v_ff,
   output logic signed [chxy_pkg::ANGLE_WIDTH-1:0]  z_ff
);

   // Stages past the end of the table add no angle.
   localparam logic signed [chxy_pkg::ANGLE_WIDTH-1:0] STEP =
      (STAGE < chxy_pkg::TABLE_LEN)
         ? chxy_pkg::ANGLE_WIDTH'(
              chxy_pkg::ATAN_TABLE[(STAGE < chxy_pkg::TABLE_LEN) ? STAGE : 0])
         : '0;

   logic signed [DATA_WIDTH-1:0]            h_in;
   logic signed [DATA_WIDTH-1:0]            v_in;
   logic signed [chxy_pkg::ANGLE_WIDTH-1:0] z_in;

   // Rotate towards the horizontal axis; both updates use the old H and V.
   always_comb begin
      if (prev_v < 0) begin
         h_in = prev_h - (prev_v >>> STAGE);
         v_in = prev_v + (prev_h >>> STAGE);
         z_in = prev_z - STEP;
      end else begin
         h_in = prev_h + (prev_v >>> STAGE);
         v_in = prev_v - (prev_h >>> STAGE);
         z_in = prev_z + STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         zero_ff <= prev_zero;
         h_ff    <= h_in;
         v_ff    <= v_in;
         z_ff    <= z_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/compass_heading_from_xy_core.sv]
// Top level of the compass heading block: pre-rotation, CORDIC pipeline and wrap.
// Depends on chxy_pkg, chxy_cordic_stage and assert_macros.svh.
//
// Usage. Each beat on the request channel (req_valid, req_stall, req_mag_x,
// req_mag_y) carries one signed magnetometer pair. The block returns one
// beat on the response channel (rsp_valid, rsp_stall, rsp_azimuth_deg) per
// request, in order: atan2(x, y) in degrees, plus the declination, wrapped
// into 0..359, plus the mounting offset, wrapped again.
// The pipeline has one pre-rotation stage, one stage per CORDIC micro-rotation
// and three stages for rounding, the first wrap and the offset wrap. A new
// pair is taken in every cycle while the receiver does not stall a waiting
// response; the unrolled micro-rotation chain makes this possible.
// When the receiver stalls a waiting response, the whole pipeline holds and
// req_stall rises in the same cycle; nothing is dropped or repeated.
// Synchronous reset empties the pipeline and loads the declination with 4 and the
// mounting offset with 70. The csr_ port writes these two registers; the user must
// use it only while no request is in flight, as the block does not enforce it.
`default_nettype none
`include "assert_macros.svh"

module compass_heading_from_xy_core #(
   parameter int SAMPLE_WIDTH    = 16,
   parameter int CORDIC_STAGES   = 16,
   parameter int ANGLE_FRAC_BITS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request channel.
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_mag_x,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_mag_y,
   // Response channel.
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [chxy_pkg::REG_WIDTH-1:0]       rsp_azimuth_deg,
   // Configuration write port.
   input  logic                                 csr_write,
   input  chxy_pkg::csr_index_type              csr_index,
   input  logic [chxy_pkg::REG_WIDTH-1:0]       csr_wdata
);

   // Vector components are samples scaled by 2^24. The CORDIC gain (about
   // 1.65) and the diagonal of the square need two more integer bits; one
   // more bit keeps a margin above the sign.
   localparam int DATA_WIDTH  = SAMPLE_WIDTH + 3 + chxy_pkg::TABLE_FRAC;
   localparam int ROUND_SHIFT = chxy_pkg::TABLE_FRAC - ANGLE_FRAC_BITS;
   localparam int HEAD_WIDTH  = ANGLE_FRAC_BITS + chxy_pkg::WHOLE_WIDTH;

   localparam logic signed [chxy_pkg::ANGLE_WIDTH-1:0] ROUND_HALF =
      chxy_pkg::ANGLE_WIDTH'(64'sd1 <<< (ROUND_SHIFT - 1));

   // The whole pipeline moves together; it holds only while a finished
   // response waits on a stalled receiver.
   logic advance;

   // Configuration registers.
   logic signed [chxy_pkg::REG_WIDTH-1:0] decl_ff;
   logic [chxy_pkg::REG_WIDTH-1:0]        offset_ff;

   // Pre-rotation stage.
   logic                                  valid0_ff;
   logic                                  zero0_ff;
   logic                                  zero0_in;
   logic signed [DATA_WIDTH-1:0]          h0_ff, h0_in;
   logic signed [DATA_WIDTH-1:0]          v0_ff, v0_in;
   logic signed [chxy_pkg::ANGLE_WIDTH-1:0] z0_ff, z0_in;
   logic signed [DATA_WIDTH-1:0]          ext_x;
   logic signed [DATA_WIDTH-1:0]          ext_y;

   // Micro-rotation chain; entry 0 is the pre-rotation stage.
   logic                                    pipe_valid [CORDIC_STAGES+1];
   logic                                    pipe_zero  [CORDIC_STAGES+1];
   logic signed [DATA_WIDTH-1:0]            pipe_h     [CORDIC_STAGES+1];
   logic signed [DATA_WIDTH-1:0]            pipe_v     [CORDIC_STAGES+1];
   logic signed [chxy_pkg::ANGLE_WIDTH-1:0] pipe_z     [CORDIC_STAGES+1];

   // Rounding and declination stage.
   logic                                    head_valid_ff;
   logic signed [HEAD_WIDTH-1:0]            head_ff, head_in;
   logic signed [chxy_pkg::ANGLE_WIDTH-1:0] angle_sel;
   logic signed [chxy_pkg::ANGLE_WIDTH-1:0] angle_round;
   logic signed [HEAD_WIDTH-1:0]            decl_ext;

   // First wrap stage.
   logic                                       rem_valid_ff;
   logic [chxy_pkg::REG_WIDTH-1:0]             rem_ff, rem_in;
   logic signed [HEAD_WIDTH-1:0]               head_shift;
   logic signed [chxy_pkg::WHOLE_WIDTH-1:0]    whole;
   logic signed [chxy_pkg::WHOLE_WIDTH-1:0]    wrap_a;
   logic signed [chxy_pkg::WHOLE_WIDTH-1:0]    wrap_b;

   // Offset wrap stage, which is also the response register.
   logic                                  rsp_valid_ff;
   logic [chxy_pkg::REG_WIDTH-1:0]        azimuth_ff, azimuth_in;
   logic [chxy_pkg::REG_WIDTH:0]          offset_sum;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_azimuth_deg = azimuth_ff;

   // ---------------------------------------------------------------------
   // Configuration registers. An unknown index cannot occur with a one-bit
   // index, so every write lands on one of the two registers.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         decl_ff   <= chxy_pkg::REG_WIDTH'(4);
         offset_ff <= chxy_pkg::REG_WIDTH'(70);
      end else if (csr_write) begin
         unique case (csr_index)
            chxy_pkg::CSR_DECLINATION:  decl_ff   <= csr_wdata;
            chxy_pkg::CSR_MOUNT_OFFSET: offset_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Pre-rotation. The horizontal part is y and the vertical part is x.
   // A vector in the left half-plane is turned by a quarter so that the
   // CORDIC only has to cover +/-90 degrees. A zero vector is flagged and
   // forced to an angle of exactly zero after the chain.
   // ---------------------------------------------------------------------
   assign ext_x = DATA_WIDTH'(req_mag_x) <<< chxy_pkg::TABLE_FRAC;
   assign ext_y = DATA_WIDTH'(req_mag_y) <<< chxy_pkg::TABLE_FRAC;

   always_comb begin
      zero0_in = (req_mag_x == '0) && (req_mag_y == '0);
      if (req_mag_y < 0) begin
         if (req_mag_x >= 0) begin
            h0_in = ext_x;
            v0_in = -ext_y;
            z0_in = chxy_pkg::QUARTER_TURN;
         end else begin
            h0_in = -ext_x;
            v0_in = ext_y;
            z0_in = -chxy_pkg::QUARTER_TURN;
         end
      end else begin
         h0_in = ext_y;
         v0_in = ext_x;
         z0_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
      end else if (advance) begin
         valid0_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         zero0_ff <= zero0_in;
         h0_ff    <= h0_in;
         v0_ff    <= v0_in;
         z0_ff    <= z0_in;
      end
   end

   assign pipe_valid[0] = valid0_ff;
   assign pipe_zero[0]  = zero0_ff;
   assign pipe_h[0]     = h0_ff;
   assign pipe_v[0]     = v0_ff;
   assign pipe_z[0]     = z0_ff;

   // ---------------------------------------------------------------------
   // One registered stage per micro-rotation.
   // ---------------------------------------------------------------------
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      chxy_cordic_stage #(
         .DATA_WIDTH (DATA_WIDTH),
         .STAGE      (i)
      ) u_stage (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .prev_valid (pipe_valid[i]),
         .prev_zero  (pipe_zero[i]),
         .prev_h     (pipe_h[i]),
         .prev_v     (pipe_v[i]),
         .prev_z     (pipe_z[i]),
         .valid_ff   (pipe_valid[i+1]),
         .zero_ff    (pipe_zero[i+1]),
         .h_ff       (pipe_h[i+1]),
         .v_ff       (pipe_v[i+1]),
         .z_ff       (pipe_z[i+1])
      );
   end

   // ---------------------------------------------------------------------
   // Round the angle to ANGLE_FRAC_BITS fraction bits (halves go up) and
   // add the whole-degree declination.
   // ---------------------------------------------------------------------
   assign angle_sel   = pipe_zero[CORDIC_STAGES] ? '0 : pipe_z[CORDIC_STAGES];
   assign angle_round = (angle_sel + ROUND_HALF) >>> ROUND_SHIFT;
   assign decl_ext    = HEAD_WIDTH'(decl_ff);
   assign head_in     = HEAD_WIDTH'(angle_round) + (decl_ext <<< ANGLE_FRAC_BITS);

   // ---------------------------------------------------------------------
   // Truncate toward zero to whole degrees, then take the floor remainder
   // by 360. The heading stays within about +/-450 degrees, so at most two
   // corrections by a full turn are needed.
   // ---------------------------------------------------------------------
   assign head_shift = head_ff >>> ANGLE_FRAC_BITS;

   always_comb begin
      whole = chxy_pkg::WHOLE_WIDTH'(head_shift);
      if (head_ff < 0 && (head_ff[ANGLE_FRAC_BITS-1:0] != '0)) begin
         whole = whole + chxy_pkg::WHOLE_WIDTH'(1);
      end
      wrap_a = (whole < 0) ? whole + chxy_pkg::FULL_TURN_S : whole;
      if (wrap_a < 0) begin
         wrap_b = wrap_a + chxy_pkg::FULL_TURN_S;
      end else if (wrap_a >= chxy_pkg::FULL_TURN_S) begin
         wrap_b = wrap_a - chxy_pkg::FULL_TURN_S;
      end else begin
         wrap_b = wrap_a;
      end
      rem_in = chxy_pkg::REG_WIDTH'(wrap_b);
   end

   // ---------------------------------------------------------------------
   // Add the mounting offset (up to 511) and wrap once more.
   // ---------------------------------------------------------------------
   always_comb begin
      offset_sum = (chxy_pkg::REG_WIDTH + 1)'(rem_ff)
                 + (chxy_pkg::REG_WIDTH + 1)'(offset_ff);
      priority if (offset_sum >= chxy_pkg::TWO_TURNS_U) begin
         azimuth_in = chxy_pkg::REG_WIDTH'(offset_sum - chxy_pkg::TWO_TURNS_U);
      end else if (offset_sum >= chxy_pkg::FULL_TURN_U) begin
         azimuth_in = chxy_pkg::REG_WIDTH'(offset_sum - chxy_pkg::FULL_TURN_U);
      end else begin
         azimuth_in = chxy_pkg::REG_WIDTH'(offset_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         rem_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else if (advance) begin
         head_valid_ff <= pipe_valid[CORDIC_STAGES];
         rem_valid_ff  <= head_valid_ff;
         rsp_valid_ff  <= rem_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         head_ff    <= head_in;
         rem_ff     <= rem_in;
         azimuth_ff <= azimuth_in;
      end
   end

   // ---------------------------------------------------------------------
   // Checks.
   // ---------------------------------------------------------------------
   // The pre-rotation must leave the vector in the right half-plane.
   `CHXY_ASSERT_NOW(a_prerot_right_half, clock, reset, valid0_ff, h0_ff >= 0)
   // The first wrap must already give a proper remainder.
   `CHXY_ASSERT_NOW(a_rem_in_range, clock, reset, rem_valid_ff, rem_ff < 9'd360)
   // A response on the port is always a heading in 0..359.
   `CHXY_ASSERT_NOW(a_azimuth_in_range, clock, reset, rsp_valid_ff, azimuth_ff < 9'd360)
   // A stalled response keeps the valid bit of the first wrap stage unchanged.
   `CHXY_ASSERT_NEXT(a_stall_freezes, clock, reset, rsp_valid_ff && rsp_stall,
                     rem_valid_ff == $past(rem_valid_ff))

endmodule

`default_nettype wire

[bench/tb_compass_heading_from_xy_core.sv]
`timescale 1ns / 1ps
// Self-checking bench for compass_heading_from_xy_core: random and directed magnetometer pairs.
// Depends on chxy_pkg and the core RTL; predicts every azimuth with its own CORDIC model.

module tb_compass_heading_from_xy_core;

   localparam int SAMPLE_BITS      = 16;
   localparam int STAGES           = 16;
   localparam int FRAC_BITS        = 8;
   // The block's pipeline depth: pre-rotation, one stage per micro-rotation, rounding and two wrap stages.
   localparam int LATENCY          = STAGES + 4;
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int RANDOM_PER_PHASE = 145;
   localparam int SETTING_PHASES   = 8;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] mag_x;
      logic signed [SAMPLE_BITS-1:0] mag_y;
   } sample_pair_type;

   // Every input of the block holds a known value from time zero.
   logic                                 clock           = 1'b0;
   logic                                 reset           = 1'b1;
   logic                                 req_valid       = 1'b0;
   logic                                 req_stall;
   logic signed [SAMPLE_BITS-1:0]        req_mag_x       = '0;
   logic signed [SAMPLE_BITS-1:0]        req_mag_y       = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall       = 1'b0;
   logic [chxy_pkg::REG_WIDTH-1:0]       rsp_azimuth_deg;
   logic                                 csr_write       = 1'b0;
   chxy_pkg::csr_index_type              csr_index       = chxy_pkg::CSR_DECLINATION;
   logic [chxy_pkg::REG_WIDTH-1:0]       csr_wdata       = '0;

   // The bench's own copy of the two registers, starting from their reset values.
   logic signed [chxy_pkg::REG_WIDTH-1:0] decl_now       = 9'sd4;
   logic [chxy_pkg::REG_WIDTH-1:0]        offset_now     = 9'd70;

   sample_pair_type                      pending_pairs[$];
   logic [chxy_pkg::REG_WIDTH-1:0]       azimuth_due[$];
   int                                   beats_owed      = 0;
   int                                   beats_sent      = 0;
   int                                   beats_checked   = 0;
   int                                   stalled_cycles  = 0;
   int                                   mismatches      = 0;
   int                                   idle_cycles     = 0;

   // Handshake bookkeeping of the clocked processes; req_taken and calm are shared between them.
   logic                                 req_taken       = 1'b0;
   logic                                 calm            = 1'b0;
   int unsigned                          gap_left        = 0;
   int unsigned                          stall_left      = 0;
   int unsigned                          mood_left       = 0;

   compass_heading_from_xy_core #(
      .SAMPLE_WIDTH    (SAMPLE_BITS),
      .CORDIC_STAGES   (STAGES),
      .ANGLE_FRAC_BITS (FRAC_BITS)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mag_x       (req_mag_x),
      .req_mag_y       (req_mag_y),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_azimuth_deg (rsp_azimuth_deg),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #10 clock = ~clock;

   // atan(2^-i) in units of 2^-24 degree, rounded to the nearest unit.
   function automatic longint micro_angle(input int stage);
      case (stage)
         0:  return 64'd754974720;
         1:  return 64'd445687602;
         2:  return 64'd235489088;
         3:  return 64'd119537938;
         4:  return 64'd60000934;
         5:  return 64'd30029717;
         6:  return 64'd15018523;
         7:  return 64'd7509720;
         8:  return 64'd3754917;
         9:  return 64'd1877466;
         10: return 64'd938734;
         11: return 64'd469367;
         12: return 64'd234684;
         13: return 64'd117342;
         14: return 64'd58671;
         15: return 64'd29335;
         16: return 64'd14668;
         17: return 64'd7334;
         18: return 64'd3667;
         19: return 64'd1833;
         20: return 64'd917;
         21: return 64'd458;
         22: return 64'd229;
         23: return 64'd115;
         default: return 64'd0;
      endcase
   endfunction

   // Heading predictor. The CORDIC runs in vectoring mode with y as the horizontal
   // part and x as the vertical part, so the accumulated angle is atan2(x, y).
   // Arithmetic right shifts on longint give the floor that the hardware uses.
   function automatic logic [chxy_pkg::REG_WIDTH-1:0] azimuth_of(
      input logic signed [SAMPLE_BITS-1:0]        mx,
      input logic signed [SAMPLE_BITS-1:0]        my,
      input logic signed [chxy_pkg::REG_WIDTH-1:0] decl,
      input logic [chxy_pkg::REG_WIDTH-1:0]        offset
   );
      longint h, v, z, dh, dv, t, ang, whole, r;
      h = longint'(my) <<< chxy_pkg::TABLE_FRAC;
      v = longint'(mx) <<< chxy_pkg::TABLE_FRAC;
      z = 0;
      // A zero vector leaves the angle at exactly zero.
      if (mx != 0 || my != 0) begin
         // Bring a vector in the left half-plane into the right one by a quarter turn.
         if (h < 0) begin
            t = h;
            if (v >= 0) begin
               h = v;
               v = -t;
               z = longint'(90) <<< chxy_pkg::TABLE_FRAC;
            end else begin
               h = -v;
               v = t;
               z = -(longint'(90) <<< chxy_pkg::TABLE_FRAC);
            end
         end
         for (int i = 0; i < STAGES; i++) begin
            dh = v >>> i;
            dv = h >>> i;
            if (v < 0) begin
               h -= dh;
               v += dv;
               z -= micro_angle(i);
            end else begin
               h += dh;
               v -= dv;
               z += micro_angle(i);
            end
         end
      end
      // Round half up to the kept fraction bits, then truncate toward zero to whole degrees.
      ang   = (z + (longint'(1) <<< (chxy_pkg::TABLE_FRAC - FRAC_BITS - 1)))
              >>> (chxy_pkg::TABLE_FRAC - FRAC_BITS);
      whole = (ang + longint'(decl) * (longint'(1) <<< FRAC_BITS)) / (longint'(1) <<< FRAC_BITS);
      r = whole % 360;
      if (r < 0)
         r += 360;
      r = (r + longint'(offset)) % 360;
      return r[chxy_pkg::REG_WIDTH-1:0];
   endfunction

   // Gap lengths: mostly none, often a few cycles, now and then a long one.
   function automatic int unsigned idle_span();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 60)
         return 0;
      if (pick < 92)
         return $urandom_range(1, 4);
      return $urandom_range(12, 45);
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] extreme_sample();
      case ($urandom_range(0, 4))
         0:       return -16'sd32768;
         1:       return -16'sd1;
         2:       return 16'sd0;
         3:       return 16'sd1;
         default: return 16'sd32767;
      endcase
   endfunction

   // Request driver. A beat stays on the bus until the monitor reports it taken;
   // after each beat the sender rests for a random number of cycles, none while calm.
   always @(negedge clock) begin : drive_request
      sample_pair_type next_pair;
      if (req_valid && !req_taken) begin
         // Held: the block has not taken the current beat yet.
      end else if (gap_left != 0) begin
         req_valid <= 1'b0;
         gap_left = gap_left - 1;
      end else if (pending_pairs.size() != 0) begin
         next_pair = pending_pairs.pop_front();
         req_valid <= 1'b1;
         req_mag_x <= next_pair.mag_x;
         req_mag_y <= next_pair.mag_y;
         gap_left = calm ? 0 : idle_span();
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Receiver stall pattern. The calm flag switches now and then so that long
   // stretches run with neither gaps nor stalls on either side.
   always @(negedge clock) begin : drive_response_stall
      if (mood_left == 0) begin
         calm <= ($urandom_range(0, 3) == 0);
         mood_left = $urandom_range(40, 250);
      end else begin
         mood_left = mood_left - 1;
      end
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left = stall_left - 1;
      end else if (calm || $urandom_range(0, 99) < 65) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= 1'b1;
         stall_left = idle_span();
      end
   end

   // Monitor. Every request beat taken produces one expected azimuth, computed
   // with the register values in force; every response beat is checked against
   // the oldest expectation. The watchdog ends a run in which nothing moves.
   always @(posedge clock) begin : watch_channels
      logic [chxy_pkg::REG_WIDTH-1:0] due;
      logic                           moved;
      moved = 1'b0;
      if (reset) begin
         req_taken <= 1'b0;
         idle_cycles = 0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            azimuth_due.push_back(azimuth_of(req_mag_x, req_mag_y, decl_now, offset_now));
            beats_owed = beats_owed - 1;
            beats_sent = beats_sent + 1;
            moved = 1'b1;
         end
         if ($isunknown(rsp_valid)) begin
            $display("%0t: rsp_valid is unknown after reset", $time);
            mismatches = mismatches + 1;
         end else if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (azimuth_due.size() == 0) begin
               $display("%0t: unexpected response beat, expected none, got azimuth_deg %0d",
                        $time, rsp_azimuth_deg);
               mismatches = mismatches + 1;
            end else begin
               due = azimuth_due.pop_front();
               beats_checked = beats_checked + 1;
               if (rsp_azimuth_deg !== due) begin
                  $display("%0t: azimuth_deg mismatch, expected %0d, got %0d",
                           $time, due, rsp_azimuth_deg);
                  mismatches = mismatches + 1;
               end
            end
         end else if (rsp_valid && rsp_stall) begin
            stalled_cycles = stalled_cycles + 1;
         end
         if (csr_write)
            moved = 1'b1;
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles, %0d responses outstanding",
                     $time, idle_cycles, azimuth_due.size());
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   task automatic push_pair(input logic signed [SAMPLE_BITS-1:0] mx,
                            input logic signed [SAMPLE_BITS-1:0] my);
      sample_pair_type pair;
      pair.mag_x = mx;
      pair.mag_y = my;
      pending_pairs.push_back(pair);
      beats_owed = beats_owed + 1;
   endtask

   // Random pairs: mostly full-range samples, with weight on tiny vectors, vectors
   // close to an axis, exact diagonals (rounding edges) and the sample extremes.
   task automatic push_random_pairs(input int count);
      int unsigned                   pick;
      logic signed [SAMPLE_BITS-1:0] mx, my, span;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            mx = SAMPLE_BITS'($urandom);
            my = SAMPLE_BITS'($urandom);
         end else if (pick < 70) begin
            mx = SAMPLE_BITS'($urandom_range(0, 16) - 8);
            my = SAMPLE_BITS'($urandom_range(0, 16) - 8);
         end else if (pick < 82) begin
            if ($urandom_range(0, 1)) begin
               mx = SAMPLE_BITS'($urandom);
               my = SAMPLE_BITS'($urandom_range(0, 4) - 2);
            end else begin
               mx = SAMPLE_BITS'($urandom_range(0, 4) - 2);
               my = SAMPLE_BITS'($urandom);
            end
         end else if (pick < 94) begin
            span = SAMPLE_BITS'($urandom_range(1, 32767));
            mx = $urandom_range(0, 1) ? span : -span;
            my = $urandom_range(0, 1) ? span : -span;
         end else begin
            mx = extreme_sample();
            my = extreme_sample();
         end
         push_pair(mx, my);
      end
   endtask

   // Waits until every beat has been taken and answered, then lets the pipeline
   // settle before the registers may be touched.
   task automatic wait_drained();
      do
         @(negedge clock);
      while (beats_owed != 0 || azimuth_due.size() != 0);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   // Both registers are written on back-to-back edges while the block is idle.
   task automatic write_registers(input logic signed [chxy_pkg::REG_WIDTH-1:0] decl,
                                  input logic [chxy_pkg::REG_WIDTH-1:0]        offset);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= chxy_pkg::CSR_DECLINATION;
      csr_wdata <= decl;
      decl_now = decl;
      @(negedge clock);
      csr_index <= chxy_pkg::CSR_MOUNT_OFFSET;
      csr_wdata <= offset;
      offset_now = offset;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // Stimulus sequence. The first phase runs on the reset values of the registers
   // and carries the directed pairs; each later phase drains the block, loads a
   // new declination and offset (the extremes first, then random ones) and sends
   // a fresh batch. Draining before each write also gives the sender its pause.
   initial begin : run_phases
      logic signed [chxy_pkg::REG_WIDTH-1:0] decl_pick;
      logic [chxy_pkg::REG_WIDTH-1:0]        offset_pick;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zero vector, the four sample extremes and the axes on both sides.
      push_pair(0, 0);
      push_pair(32767, 32767);
      push_pair(-32768, -32768);
      push_pair(-32768, 32767);
      push_pair(32767, -32768);
      push_pair(0, 32767);
      push_pair(32767, 0);
      push_pair(-32768, 0);
      // Negative horizontal part: with a zero vertical part the upper pre-rotation
      // applies, with a negative one the lower.
      push_pair(0, -32768);
      push_pair(-1, -32768);
      push_pair(1, -32768);
      push_pair(-32768, -1);
      // Unit vectors and diagonals in every quadrant.
      push_pair(1, 0);
      push_pair(0, 1);
      push_pair(-1, 0);
      push_pair(0, -1);
      push_pair(1, 1);
      push_pair(-1, -1);
      push_pair(1, -1);
      push_pair(-1, 1);
      push_pair(21845, -10923);
      push_random_pairs(RANDOM_PER_PHASE);

      for (int phase = 1; phase < SETTING_PHASES; phase++) begin
         wait_drained();
         case (phase)
            1: begin
               decl_pick = -9'sd180;
               offset_pick = 9'd0;
            end
            2: begin
               decl_pick = 9'sd180;
               offset_pick = 9'd359;
            end
            // Values outside the documented range are used as given.
            3: begin
               decl_pick = -9'sd256;
               offset_pick = 9'd511;
            end
            4: begin
               decl_pick = 9'sd255;
               offset_pick = 9'd0;
            end
            5: begin
               decl_pick = 9'sd0;
               offset_pick = 9'd359;
            end
            6: begin
               decl_pick = chxy_pkg::REG_WIDTH'($urandom_range(0, 360) - 180);
               offset_pick = chxy_pkg::REG_WIDTH'($urandom_range(0, 359));
            end
            default: begin
               decl_pick = chxy_pkg::REG_WIDTH'($urandom);
               offset_pick = chxy_pkg::REG_WIDTH'($urandom);
            end
         endcase
         write_registers(decl_pick, offset_pick);
         @(posedge clock);
         push_pair(0, 0);
         push_pair(0, -32768);
         push_pair(-1, -32768);
         push_random_pairs(RANDOM_PER_PHASE);
      end

      wait_drained();
      $display("Run covered %0d sample pairs (%0d checked) over %0d register settings,",
               beats_sent, beats_checked, SETTING_PHASES);
      $display("with %0d stalled response cycles and %0d mismatches.",
               stalled_cycles, mismatches);
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
